>>> rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared types and constants for the controller, datapath and table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int TABLE_AW    = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_WORD_W  = 64;
  localparam int KEY_VEC_W   = KEY_WORDS * KEY_WORD_W;
  localparam int KEY_IDX_W   = 5;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

  localparam logic [LEN_W-1:0] KEY_LEN_RST = 6'd16;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic              end_of_block_out;
  } out_item_t;

  typedef enum logic [2:0] {
    RD_I_NEXT,
    RD_I,
    RD_J_DATA,
    RD_J_KEY,
    RD_T
  } rd_sel_t;

  typedef enum logic [1:0] {
    J_HOLD,
    J_DATA,
    J_KEY
  } j_op_t;

  typedef enum logic {
    WR_I_RD,
    WR_J_A
  } wr_sel_t;

  typedef struct packed {
    logic    ld_in;
    logic    inc_i;
    logic    clr_idx;
    logic    clr_tab;
    logic    ld_a;
    logic    ld_b;
    j_op_t   j_op;
    logic    re;
    rd_sel_t rd_sel;
    logic    we;
    wr_sel_t wr_sel;
    logic    step_k;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/rc4_perm_mem.sv
// ----------------------------------------------------------------------------
// RC4 permutation table memory
// 256 x 8 table with one write and one registered read port. Entries that
// have not been written since reset or the last clear read as their address.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_perm_mem (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          we,
  input  wire logic [rc4_pkg::TABLE_AW-1:0]  waddr,
  input  wire logic [rc4_pkg::BYTE_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [rc4_pkg::TABLE_AW-1:0]  raddr,
  output logic      [rc4_pkg::BYTE_W-1:0]    rdata
);

  logic [rc4_pkg::BYTE_W-1:0]      mem [rc4_pkg::TABLE_DEPTH];
  logic [rc4_pkg::TABLE_DEPTH-1:0] vld_r;
  logic [rc4_pkg::BYTE_W-1:0]      mem_q_r;
  logic                            vld_q_r;
  logic [rc4_pkg::TABLE_AW-1:0]    addr_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_q_r  <= mem[raddr];
      vld_q_r  <= vld_r[raddr];
      addr_q_r <= raddr;
    end
  end

  assign rdata = vld_q_r ? mem_q_r : addr_q_r;

endmodule

`default_nettype wire

>>> rtl/core/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the table accesses of a keystream step and of the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  input  wire rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_D1   = 8'b0000_0010,
    ST_D2   = 8'b0000_0100,
    ST_D3   = 8'b0000_1000,
    ST_K0   = 8'b0001_0000,
    ST_K1   = 8'b0010_0000,
    ST_K2   = 8'b0100_0000,
    ST_K3   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.j_op   = rc4_pkg::J_HOLD;
    cmd.rd_sel = rc4_pkg::RD_I;
    cmd.wr_sel = rc4_pkg::WR_I_RD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            cmd.clr_tab = 1'b1;
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_K0;
          end else begin
            cmd.ld_in  = 1'b1;
            cmd.inc_i  = 1'b1;
            cmd.re     = 1'b1;
            cmd.rd_sel = rc4_pkg::RD_I_NEXT;
            state_nxt  = ST_D1;
          end
        end
      end
      ST_D1: begin
        cmd.re     = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_J_DATA;
        cmd.ld_a   = 1'b1;
        cmd.j_op   = rc4_pkg::J_DATA;
        state_nxt  = ST_D2;
      end
      ST_D2: begin
        cmd.re     = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_T;
        cmd.ld_b   = 1'b1;
        cmd.we     = 1'b1;
        cmd.wr_sel = rc4_pkg::WR_I_RD;
        state_nxt  = ST_D3;
      end
      ST_D3: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = rc4_pkg::WR_J_A;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_K0: begin
        cmd.re     = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_I;
        state_nxt  = ST_K1;
      end
      ST_K1: begin
        cmd.re     = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_J_KEY;
        cmd.ld_a   = 1'b1;
        cmd.j_op   = rc4_pkg::J_KEY;
        state_nxt  = ST_K2;
      end
      ST_K2: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = rc4_pkg::WR_I_RD;
        state_nxt  = ST_K3;
      end
      ST_K3: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = rc4_pkg::WR_J_A;
        if (sts.last_step) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.inc_i  = 1'b1;
          cmd.step_k = 1'b1;
          state_nxt  = ST_K0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rc4_dp.sv
// ----------------------------------------------------------------------------
// RC4 datapath
// Indices, key byte counter, table memory, swap operands and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rc4_pkg::cmd_t                     cmd,
  input  wire rc4_pkg::in_item_t                 in_data,
  input  wire logic [rc4_pkg::KEY_VEC_W-1:0]     key_vec,
  input  wire logic [rc4_pkg::LEN_W-1:0]         key_len,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output rc4_pkg::out_item_t                     out_data,
  output rc4_pkg::sts_t                          sts
);

  logic [rc4_pkg::BYTE_W-1:0]    i_r, i_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    j_r, j_nxt;
  logic [rc4_pkg::KEY_IDX_W-1:0] k_r, k_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    a_r;
  logic [rc4_pkg::BYTE_W-1:0]    b_r;
  logic [rc4_pkg::BYTE_W-1:0]    data_r;
  logic                          eob_r;
  logic                          out_valid_r, out_valid_nxt;
  rc4_pkg::out_item_t            out_data_r;

  logic [rc4_pkg::BYTE_W-1:0]    rd;
  logic [rc4_pkg::TABLE_AW-1:0]  raddr;
  logic [rc4_pkg::TABLE_AW-1:0]  waddr;
  logic [rc4_pkg::BYTE_W-1:0]    wdata;
  logic [rc4_pkg::BYTE_W-1:0]    key_byte;
  logic [rc4_pkg::BYTE_W-1:0]    j_data;
  logic [rc4_pkg::BYTE_W-1:0]    j_key;
  logic [rc4_pkg::BYTE_W-1:0]    t_rd;
  logic [rc4_pkg::BYTE_W-1:0]    t_hold;
  logic [rc4_pkg::BYTE_W-1:0]    ks;
  logic [rc4_pkg::LEN_W-1:0]     k_inc;

  assign key_byte = key_vec[{k_r, 3'b000} +: rc4_pkg::BYTE_W];
  assign j_data   = j_r + rd;
  assign j_key    = j_r + rd + key_byte;
  assign t_rd     = a_r + rd;
  assign t_hold   = a_r + b_r;
  assign k_inc    = {1'b0, k_r} + 6'd1;

  always_comb begin
    unique case (cmd.rd_sel)
      rc4_pkg::RD_I_NEXT: raddr = i_r + 8'd1;
      rc4_pkg::RD_I:      raddr = i_r;
      rc4_pkg::RD_J_DATA: raddr = j_data;
      rc4_pkg::RD_J_KEY:  raddr = j_key;
      rc4_pkg::RD_T:      raddr = t_rd;
      default:            raddr = i_r;
    endcase
  end

  assign waddr = (cmd.wr_sel == rc4_pkg::WR_I_RD) ? i_r : j_r;
  assign wdata = (cmd.wr_sel == rc4_pkg::WR_I_RD) ? rd : a_r;

  rc4_perm_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cmd.clr_tab),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.re),
    .raddr (raddr),
    .rdata (rd)
  );

  // The swap may not be in the table yet when the output entry is read, so
  // an output index that hits a swapped entry takes the swapped value.
  always_comb begin
    priority if (t_hold == i_r) begin
      ks = b_r;
    end else if (t_hold == j_r) begin
      ks = a_r;
    end else begin
      ks = rd;
    end
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (cmd.clr_idx) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else begin
      if (cmd.inc_i) begin
        i_nxt = i_r + 8'd1;
      end
      unique case (cmd.j_op)
        rc4_pkg::J_DATA: j_nxt = j_data;
        rc4_pkg::J_KEY:  j_nxt = j_key;
        default:         j_nxt = j_r;
      endcase
      if (cmd.step_k) begin
        k_nxt = (k_inc == key_len) ? '0 : k_inc[rc4_pkg::KEY_IDX_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      a_r <= rd;
    end
    if (cmd.ld_b) begin
      b_r <= rd;
    end
    if (cmd.ld_in) begin
      data_r <= in_data.data_byte;
      eob_r  <= in_data.end_of_block;
    end
    if (cmd.out_ld) begin
      out_data_r.cipher_byte      <= ks ^ data_r;
      out_data_r.end_of_block_out <= eob_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.last_step = (i_r == 8'hFF);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> rtl/core/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Key schedule and keystream generator over a 256-entry permutation table.
// ----------------------------------------------------------------------------
// The key is loaded through the cfg_ port: indexes 0 to 3 hold the key words,
// index 4 the key length in bytes. Writes are taken in every cycle and are
// expected only while the unit is idle.
// An input transaction with mode set runs the key schedule and returns no
// result; for every table position in turn it reads S[i], then S[j] for the
// new j, and writes both entries back swapped.
// An input transaction with mode clear produces one output transaction; the
// next input is taken only after acceptance, the read of S[j], the read of
// the output entry with the write of S[i], and the write of S[j].
// A finished result waits in the output register; if the receiver stalls,
// the unit holds the following item in its last step until the register is
// free.
// Reset restores the identity table at once through per-entry valid flags,
// clears both indices and sets the key to zero with a length of 16.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rc4_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rc4_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [rc4_pkg::LEN_W-1:0] MaxLen = rc4_pkg::LEN_W'(MAX_KEY_BYTES);

  logic [rc4_pkg::KEY_WORDS-1:0][rc4_pkg::KEY_WORD_W-1:0] key_word_r;
  logic [rc4_pkg::LEN_W-1:0]                              key_length_r;
  logic [rc4_pkg::LEN_W-1:0]                              key_len_eff;
  rc4_pkg::cmd_t                                          cmd;
  rc4_pkg::sts_t                                          sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_r   <= '0;
      key_length_r <= rc4_pkg::KEY_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rc4_pkg::CFG_KEY_WORD_0: key_word_r[0] <= cfg_data;
        rc4_pkg::CFG_KEY_WORD_1: key_word_r[1] <= cfg_data;
        rc4_pkg::CFG_KEY_WORD_2: key_word_r[2] <= cfg_data;
        rc4_pkg::CFG_KEY_WORD_3: key_word_r[3] <= cfg_data;
        rc4_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_data[rc4_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (key_length_r == '0) begin
      key_len_eff = 6'd1;
    end else if (key_length_r > MaxLen) begin
      key_len_eff = MaxLen;
    end else begin
      key_len_eff = key_length_r;
    end
  end

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rc4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .key_vec   (key_word_r),
    .key_len   (key_len_eff),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> rtl/core/rc4_sva_chk.sv
// ----------------------------------------------------------------------------
// RC4 port checker
// Concurrent assertions on the top-level ports, bound to the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_sva_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire rc4_pkg::in_item_t              in_data,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire rc4_pkg::out_item_t             out_data,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Every accepted transaction keeps the unit busy, with in_ready low, before another input is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted again too early");

  // A data transaction accepted while the output stage is empty must yield a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_data.mode && !out_valid |-> ##4 out_valid)
    else $error("data transaction produced no result in time");

  // A rekey transaction keeps the unit busy before it can take another input.
  a_rekey_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("key schedule finished too early");

endmodule

bind rc4_stream_cipher_unit rc4_sva_chk u_rc4_sva_chk (.*);

`default_nettype wire
